[rtl/plu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the PCM linear upsampler.
// No dependencies; every other file imports this package.
package plu_pkg;

  localparam int MAX_CHAN          = 6;
  localparam int MAX_WHOLE_REPEATS = 24;
  localparam longint unsigned FULL_WORD  = 64'hFFFF_FFFF;
  localparam longint unsigned MATCH_RATE = 48000;
  localparam int UNIT_SCALE = int'(FULL_WORD / MATCH_RATE);

  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 3;
  localparam int REP_W      = 5;
  localparam int FRAC_W     = 17;
  localparam int ACC_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DIV_CNT_W  = $clog2(SAMPLE_W);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAN_COUNT    = 2'd0,
    REG_WHOLE_REPEATS = 2'd1,
    REG_FRAC_STEP     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_count;
    logic [REP_W-1:0]  next_repeats;
    logic              restart;
  } plu_cfg_t;

endpackage

[rtl/plu_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input frames and output frames.
// Depends on plu_pkg for the sample type.
interface plu_in_if;
  import plu_pkg::*;
  logic    valid;
  logic    ready;
  sample_t in_ch0;
  sample_t in_ch1;
  sample_t in_ch2;
  sample_t in_ch3;
  sample_t in_ch4;
  sample_t in_ch5;
  logic    end_of_block;

  modport source (output valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5,
                  end_of_block, input ready);
  modport sink (input valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5,
                end_of_block, output ready);
endinterface

interface plu_out_if;
  import plu_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_ch0;
  sample_t out_ch1;
  sample_t out_ch2;
  sample_t out_ch3;
  sample_t out_ch4;
  sample_t out_ch5;
  logic    last_of_run;

  modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                  last_of_run, input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                last_of_run, output ready);
endinterface

[rtl/pcm_linear_upsampler_unit.sv]
`timescale 1ns / 1ps
// Top level of the PCM linear upsampler: sequencer, frame registers and output register.
// Depends on plu_pkg, plu_ifs, plu_cfg and plu_div.
//
// Each accepted frame is held until the next frame arrives; that arrival emits the held
// frame's repeat count n of output frames, interpolated toward the new frame, one output
// beat per cycle while the output is not stalled. The per-channel step comes from one
// shared bit-serial divider, so when n > 1 an item first runs one division per channel
// in use (load, quotient bits and hand-off), then the emit state, then the commit state;
// end_of_block adds the flush run of the new frame's count, again one beat per cycle
// while the output is not stalled. Input ready is low for the whole item. Output
// backpressure only stretches the emit cycles.
module pcm_linear_upsampler_unit import plu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  plu_in_if.sink                in_chan,
  plu_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DLOAD  = 5'b00010,
    S_DWAIT  = 5'b00100,
    S_EMIT   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  plu_cfg_t          cfg;
  logic              advance;
  logic              div_start;
  logic              div_done;
  sample_t           div_q;
  sample_t           div_dvd;

  sample_t           in_smp [MAX_CHAN];
  sample_t           new_r [MAX_CHAN], new_nxt [MAX_CHAN];
  sample_t           held_r [MAX_CHAN], held_nxt [MAX_CHAN];
  sample_t           step_r [MAX_CHAN], step_nxt [MAX_CHAN];
  sample_t           sum_r [MAX_CHAN], sum_nxt [MAX_CHAN];
  sample_t           emit_val [MAX_CHAN];
  sample_t           out_data_r [MAX_CHAN], out_data_nxt [MAX_CHAN];
  logic              eob_r, eob_nxt;
  logic              frame_held_r, frame_held_nxt;
  logic [REP_W-1:0]  held_rep_r, held_rep_nxt;
  logic [REP_W-1:0]  k_r, k_nxt;
  logic [CHAN_W-1:0] ch_r, ch_nxt;
  logic              phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic              in_fire;
  logic              emit_go;
  logic              last_k;

  plu_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .advance  (advance),
    .cfg      (cfg)
  );

  assign div_dvd = new_r[ch_r] - held_r[ch_r];

  plu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (held_rep_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_smp[0] = in_chan.in_ch0;
  assign in_smp[1] = in_chan.in_ch1;
  assign in_smp[2] = in_chan.in_ch2;
  assign in_smp[3] = in_chan.in_ch3;
  assign in_smp[4] = in_chan.in_ch4;
  assign in_smp[5] = in_chan.in_ch5;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign emit_go       = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);
  assign last_k        = (k_r == held_rep_r - REP_W'(1));

  always_comb begin
    state_nxt      = state_r;
    new_nxt        = new_r;
    held_nxt       = held_r;
    step_nxt       = step_r;
    sum_nxt        = sum_r;
    out_data_nxt   = out_data_r;
    eob_nxt        = eob_r;
    frame_held_nxt = frame_held_r;
    held_rep_nxt   = held_rep_r;
    k_nxt          = k_r;
    ch_nxt         = ch_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;
    advance        = 1'b0;

    for (int c = 0; c < MAX_CHAN; c++) begin
      emit_val[c] = (CHAN_W'(c) < cfg.chan_count) ? sample_t'(held_r[c] + sum_r[c]) : '0;
    end

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          new_nxt   = in_smp;
          eob_nxt   = in_chan.end_of_block;
          k_nxt     = '0;
          ch_nxt    = '0;
          phase_nxt = 1'b0;
          for (int c = 0; c < MAX_CHAN; c++) begin
            step_nxt[c] = '0;
            sum_nxt[c]  = '0;
          end
          if (frame_held_r && held_rep_r > REP_W'(1)) begin
            state_nxt = S_DLOAD;
          end else if (frame_held_r && held_rep_r == REP_W'(1)) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_DLOAD: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          step_nxt[ch_r] = div_q;
          if (ch_r == cfg.chan_count - CHAN_W'(1)) begin
            state_nxt = S_EMIT;
          end else begin
            ch_nxt    = ch_r + CHAN_W'(1);
            state_nxt = S_DLOAD;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = emit_val;
          out_last_nxt  = last_k && (phase_r || !eob_r || cfg.next_repeats == '0);
          for (int c = 0; c < MAX_CHAN; c++) begin
            sum_nxt[c] = sum_r[c] + step_r[c];
          end
          k_nxt = k_r + REP_W'(1);
          if (last_k) begin
            if (phase_r) begin
              frame_held_nxt = 1'b0;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_COMMIT;
            end
          end
        end
      end
      S_COMMIT: begin
        held_nxt       = new_r;
        held_rep_nxt   = cfg.next_repeats;
        advance        = 1'b1;
        frame_held_nxt = 1'b1;
        k_nxt          = '0;
        for (int c = 0; c < MAX_CHAN; c++) begin
          step_nxt[c] = '0;
          sum_nxt[c]  = '0;
        end
        if (eob_r) begin
          phase_nxt = 1'b1;
          if (cfg.next_repeats == '0) begin
            frame_held_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg.restart) begin
      frame_held_nxt = 1'b0;
      held_rep_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_held_r <= 1'b0;
      held_rep_r   <= '0;
      k_r          <= '0;
      ch_r         <= '0;
      phase_r      <= 1'b0;
      eob_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_held_r <= frame_held_nxt;
      held_rep_r   <= held_rep_nxt;
      k_r          <= k_nxt;
      ch_r         <= ch_nxt;
      phase_r      <= phase_nxt;
      eob_r        <= eob_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r      <= new_nxt;
    held_r     <= held_nxt;
    step_r     <= step_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_ch0     = out_data_r[0];
  assign out_chan.out_ch1     = out_data_r[1];
  assign out_chan.out_ch2     = out_data_r[2];
  assign out_chan.out_ch3     = out_data_r[3];
  assign out_chan.out_ch4     = out_data_r[4];
  assign out_chan.out_ch5     = out_data_r[5];
  assign out_chan.last_of_run = out_last_r;

endmodule

[rtl/plu_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers and fractional repeat accumulator.
// Depends on plu_pkg.
module plu_cfg import plu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  advance,
  output plu_cfg_t              cfg
);

  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic [REP_W-1:0]  whole_r, whole_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [ACC_W-1:0]  accum_r, accum_nxt;
  logic [REP_W-1:0]  next_r, next_nxt;
  logic              restart;
  logic [ACC_W-1:0]  adv_a;
  logic [FRAC_W-1:0] adv_b;
  logic [REP_W-1:0]  adv_whole;
  logic [ACC_W:0]    adv_sum;
  logic              adv_over;

  always_comb begin
    chan_nxt  = chan_r;
    whole_nxt = whole_r;
    frac_nxt  = frac_r;
    restart   = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_CHAN_COUNT: begin
          restart = 1'b1;
          if (cfg_data[CHAN_W-1:0] == '0) begin
            chan_nxt = CHAN_W'(1);
          end else if (cfg_data[CHAN_W-1:0] > CHAN_W'(MAX_CHAN)) begin
            chan_nxt = CHAN_W'(MAX_CHAN);
          end else begin
            chan_nxt = cfg_data[CHAN_W-1:0];
          end
        end
        REG_WHOLE_REPEATS: begin
          restart = 1'b1;
          if (cfg_data[REP_W-1:0] > REP_W'(MAX_WHOLE_REPEATS)) begin
            whole_nxt = REP_W'(MAX_WHOLE_REPEATS);
          end else begin
            whole_nxt = cfg_data[REP_W-1:0];
          end
        end
        REG_FRAC_STEP: begin
          restart = 1'b1;
          if (cfg_data[FRAC_W-1:0] > FRAC_W'(UNIT_SCALE - 1)) begin
            frac_nxt = FRAC_W'(UNIT_SCALE - 1);
          end else begin
            frac_nxt = cfg_data[FRAC_W-1:0];
          end
        end
        default: ;
      endcase
    end

    // restart seeds the accumulator with the step, then advances once
    adv_a     = restart ? ACC_W'(frac_nxt) : accum_r;
    adv_b     = restart ? frac_nxt : frac_r;
    adv_whole = restart ? whole_nxt : whole_r;
    adv_sum   = {1'b0, adv_a} + (ACC_W+1)'(adv_b);
    adv_over  = adv_sum > (ACC_W+1)'(UNIT_SCALE);

    accum_nxt = accum_r;
    next_nxt  = next_r;
    if (restart || advance) begin
      accum_nxt = adv_over ? ACC_W'(adv_sum - (ACC_W+1)'(UNIT_SCALE)) : adv_sum[ACC_W-1:0];
      next_nxt  = adv_whole + REP_W'(adv_over);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= CHAN_W'(1);
      whole_r <= REP_W'(1);
      frac_r  <= '0;
      accum_r <= '0;
      next_r  <= REP_W'(1);
    end else begin
      chan_r  <= chan_nxt;
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
      accum_r <= accum_nxt;
      next_r  <= next_nxt;
    end
  end

  assign cfg.chan_count   = chan_r;
  assign cfg.next_repeats = next_r;
  assign cfg.restart      = restart;

endmodule

[rtl/plu_div.sv]
`timescale 1ns / 1ps
// Bit-serial signed divider: 16-bit sample by 5-bit repeat count,
// truncating toward zero, one quotient bit per cycle. Depends on plu_pkg.
module plu_div import plu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sample_t          dividend,
  input  logic [REP_W-1:0] divisor,
  output logic             done,
  output sample_t          quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SAMPLE_W-1:0]  mag_r;
  logic [REP_W-1:0]     rem_r;
  logic [REP_W-1:0]     dsr_r;
  logic                 neg_r;
  logic [REP_W:0]       trial;
  logic [REP_W:0]       diff;
  logic                 ge;

  assign trial = {rem_r, mag_r[SAMPLE_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(SAMPLE_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(SAMPLE_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= dividend[SAMPLE_W-1] ? SAMPLE_W'(~dividend + SAMPLE_W'(1)) : dividend;
      rem_r <= '0;
      dsr_r <= divisor;
      neg_r <= dividend[SAMPLE_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[REP_W-1:0] : trial[REP_W-1:0];
      mag_r <= {mag_r[SAMPLE_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? sample_t'(~mag_r + SAMPLE_W'(1)) : sample_t'(mag_r);

endmodule

[rtl/plu_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the PCM linear upsampler, bound to the top level.
// Depends on plu_pkg and pcm_linear_upsampler_unit.
module plu_chk import plu_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [6*SAMPLE_W:0]       out_beat
);

  // hold off new frames while a frame is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after an accepted beat");

  a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("output beat appeared without a frame in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before the beat was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_beat))
    else $error("output payload changed while stalled");

endmodule

bind pcm_linear_upsampler_unit plu_chk u_plu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_beat  ({out_chan.last_of_run, out_chan.out_ch5, out_chan.out_ch4, out_chan.out_ch3,
               out_chan.out_ch2, out_chan.out_ch1, out_chan.out_ch0})
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for pcm_linear_upsampler_unit: directed table plus random frame streams,
// each beat compared with an in-bench interpolation predictor or a typed expected frame. Needs plu_pkg and plu_ifs.
module testbench;
  import plu_pkg::*;

  localparam int SETTLE       = 300;
  localparam int LONG_HOLD    = 600;
  localparam int PHASE_FRAMES = 25;
  localparam int RUN_LIMIT_NS = 20_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic                       flag;
    sample_t [MAX_CHAN-1:0]     ch;
  } pcm_frame_t;

  typedef struct packed {
    logic                  is_cfg;
    logic                  typed;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pcm_frame_t            frame;
    pcm_frame_t            want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  plu_in_if  in_bus ();
  plu_out_if out_bus ();

  pcm_linear_upsampler_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  int cur_chans;
  int cur_whole;
  int cur_frac;
  int frac_acc;
  int held_count;
  int next_count;
  sample_t held_smp [MAX_CHAN];
  bit held_live;

  pcm_frame_t frames_due [$];
  pcm_frame_t fresh_q [$];

  int err_count;
  int frame_count;
  int beat_count;
  int cfg_count;
  bit sink_long_hold;

  function automatic pcm_frame_t mk(int a0, int a1, int a2, int a3, int a4, int a5, bit flag);
    pcm_frame_t f;
    f.ch[0] = sample_t'(a0);
    f.ch[1] = sample_t'(a1);
    f.ch[2] = sample_t'(a2);
    f.ch[3] = sample_t'(a3);
    f.ch[4] = sample_t'(a4);
    f.ch[5] = sample_t'(a5);
    f.flag  = flag;
    return f;
  endfunction

  function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic stim_row_t row_frame(pcm_frame_t f);
    stim_row_t r;
    r = '0;
    r.frame = f;
    return r;
  endfunction

  function automatic stim_row_t row_typed(pcm_frame_t f, pcm_frame_t w);
    stim_row_t r;
    r = '0;
    r.typed = 1'b1;
    r.frame = f;
    r.want  = w;
    return r;
  endfunction

  function automatic void bump_count();
    int n;
    n = cur_whole;
    frac_acc += cur_frac;
    if (frac_acc > UNIT_SCALE) begin
      frac_acc -= UNIT_SCALE;
      n++;
    end
    next_count = n;
  endfunction

  function automatic void restart_state();
    int c;
    for (c = 0; c < MAX_CHAN; c++) held_smp[c] = '0;
    held_live  = 1'b0;
    held_count = 0;
    frac_acc   = cur_frac;
    bump_count();
  endfunction

  // Append one run of the held frame, stepping toward tgt unless flat.
  function automatic void emit_run(pcm_frame_t tgt, bit flat);
    sample_t stp [MAX_CHAN];
    sample_t acc [MAX_CHAN];
    sample_t d;
    pcm_frame_t o;
    int c, k;
    for (c = 0; c < MAX_CHAN; c++) begin
      stp[c] = '0;
      acc[c] = '0;
      if (!flat && held_count > 1 && c < cur_chans) begin
        d = sample_t'(tgt.ch[c]) - held_smp[c];
        stp[c] = sample_t'(int'(d) / held_count);
      end
    end
    for (k = 0; k < held_count; k++) begin
      o = '0;
      for (c = 0; c < MAX_CHAN; c++) begin
        if (c < cur_chans) begin
          o.ch[c] = held_smp[c] + acc[c];
          acc[c] = acc[c] + stp[c];
        end
      end
      fresh_q.push_back(o);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int v;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_count++;
    case (idx)
      REG_CHAN_COUNT: begin
        v = int'(data[CHAN_W-1:0]);
        if (v < 1) v = 1;
        if (v > MAX_CHAN) v = MAX_CHAN;
        cur_chans = v;
        restart_state();
      end
      REG_WHOLE_REPEATS: begin
        v = int'(data[REP_W-1:0]);
        if (v > MAX_WHOLE_REPEATS) v = MAX_WHOLE_REPEATS;
        cur_whole = v;
        restart_state();
      end
      REG_FRAC_STEP: begin
        v = int'(data[FRAC_W-1:0]);
        if (v > UNIT_SCALE - 1) v = UNIT_SCALE - 1;
        cur_frac = v;
        restart_state();
      end
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained(input int settle);
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (frames_due.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic offer_frame(input pcm_frame_t f, input int gap, input bit typed,
                             input pcm_frame_t want);
    int c, k;
    pcm_frame_t o;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.in_ch0       <= f.ch[0];
    in_bus.in_ch1       <= f.ch[1];
    in_bus.in_ch2       <= f.ch[2];
    in_bus.in_ch3       <= f.ch[3];
    in_bus.in_ch4       <= f.ch[4];
    in_bus.in_ch5       <= f.ch[5];
    in_bus.end_of_block <= f.flag;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    frame_count++;
    fresh_q.delete();
    if (held_live) emit_run(f, 1'b0);
    for (c = 0; c < MAX_CHAN; c++) held_smp[c] = f.ch[c];
    held_count = next_count;
    held_live  = 1'b1;
    bump_count();
    if (f.flag) begin
      emit_run(f, 1'b1);
      held_live = 1'b0;
    end
    if (fresh_q.size() > 0) begin
      o = fresh_q.pop_back();
      o.flag = 1'b1;
      fresh_q.push_back(o);
    end
    if (typed) begin
      frames_due.push_back(want);
    end else begin
      for (k = 0; k < fresh_q.size(); k++) frames_due.push_back(fresh_q[k]);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("pcm_linear_upsampler_unit regression: fail");
    $finish;
  end

  initial begin : sink_pacing
    int r, len;
    logic lvl;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_long_hold) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        sink_long_hold = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        lvl = 1'b1;
        len = $urandom_range(1, 12);
      end else if (r < 65) begin
        lvl = 1'b1;
        len = $urandom_range(50, 200);
      end else if (r < 92) begin
        lvl = 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        lvl = 1'b0;
        len = $urandom_range(8, 40);
      end
      out_bus.ready <= lvl;
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin : beat_check
    pcm_frame_t got, want;
    int c;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.ch[0] = out_bus.out_ch0;
      got.ch[1] = out_bus.out_ch1;
      got.ch[2] = out_bus.out_ch2;
      got.ch[3] = out_bus.out_ch3;
      got.ch[4] = out_bus.out_ch4;
      got.ch[5] = out_bus.out_ch5;
      got.flag  = out_bus.last_of_run;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("output beat %0d with no frame expected", beat_count));
      end else begin
        want = frames_due.pop_front();
        for (c = 0; c < MAX_CHAN; c++) begin
          if (got.ch[c] !== want.ch[c])
            report_mismatch($sformatf("beat %0d out_ch%0d got %0d want %0d", beat_count, c,
                                      $signed(got.ch[c]), $signed(want.ch[c])));
        end
        if (got.flag !== want.flag)
          report_mismatch($sformatf("beat %0d last_of_run got %b want %b", beat_count,
                                    got.flag, want.flag));
      end
      beat_count++;
    end
  end

  initial begin : stimulus
    stim_row_t rows [$];
    stim_row_t r;
    pcm_frame_t f, last_sent;
    logic [CFG_DATA_W-1:0] cc_d, wr_d, fs_d;
    int p, i, c, k;
    bit cfg_open, no_idle;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.in_ch0       <= '0;
    in_bus.in_ch1       <= '0;
    in_bus.in_ch2       <= '0;
    in_bus.in_ch3       <= '0;
    in_bus.in_ch4       <= '0;
    in_bus.in_ch5       <= '0;
    in_bus.end_of_block <= 1'b0;
    sink_long_hold = 1'b0;
    last_sent = '0;
    cfg_open = 1'b0;
    err_count = 0;
    frame_count = 0;
    beat_count = 0;
    cfg_count = 0;

    cur_chans = 1;
    cur_whole = 1;
    cur_frac  = 0;
    restart_state();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one channel, one frame per run
    rows.push_back(row_frame(mk(32767, 1111, -2222, 3333, -4444, 5555, 0)));
    rows.push_back(row_typed(mk(-32768, 7, 7, 7, 7, 7, 0), mk(32767, 0, 0, 0, 0, 0, 1)));
    rows.push_back(row_frame(mk(0, -1, -1, -1, -1, -1, 1)));
    rows.push_back(row_typed(mk(-1, 9, 9, 9, 9, 9, 1), mk(-1, 0, 0, 0, 0, 0, 1)));
    rows.push_back(row_frame(mk(12345, 1, 2, 3, 4, 5, 0)));
    // spare index must not disturb the held frame
    rows.push_back(row_cfg(REG_SPARE, 17'h1FFFF));
    rows.push_back(row_typed(mk(100, 0, 0, 0, 0, 0, 0), mk(12345, 0, 0, 0, 0, 0, 1)));
    // saturating writes: six channels, 25-frame runs
    rows.push_back(row_cfg(REG_CHAN_COUNT, 17'h1FFFF));
    rows.push_back(row_cfg(REG_WHOLE_REPEATS, 17'h0001F));
    rows.push_back(row_cfg(REG_FRAC_STEP, 17'h1FFFF));
    rows.push_back(row_frame(mk(32767, 32767, 32767, 32767, 32767, 32767, 0)));
    rows.push_back(row_frame(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0)));
    rows.push_back(row_frame(mk(32767, -32768, 32767, -32768, 0, -1, 1)));
    // zero channels reads as one, zero repeats emits nothing
    rows.push_back(row_cfg(REG_CHAN_COUNT, 17'h00000));
    rows.push_back(row_cfg(REG_WHOLE_REPEATS, 17'h00000));
    rows.push_back(row_cfg(REG_FRAC_STEP, 17'h00000));
    rows.push_back(row_frame(mk(1000, 2000, 3000, 4000, 5000, 6000, 0)));
    rows.push_back(row_frame(mk(-1000, -2000, -3000, -4000, -5000, -6000, 1)));
    // two-frame runs: truncation toward zero on odd deltas
    rows.push_back(row_cfg(REG_CHAN_COUNT, 17'h00003));
    rows.push_back(row_cfg(REG_WHOLE_REPEATS, 17'h00002));
    rows.push_back(row_frame(mk(0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(row_frame(mk(-3, 3, -32768, 5, 5, 5, 0)));
    rows.push_back(row_frame(mk(32767, -32768, 1, 5, 5, 5, 1)));
    rows.push_back(row_cfg(REG_CHAN_COUNT, 17'h00006));
    rows.push_back(row_cfg(REG_WHOLE_REPEATS, 17'h00001));
    rows.push_back(row_cfg(REG_FRAC_STEP, 17'd89477));
    rows.push_back(row_frame(mk(-7, 7, -100, 100, 32767, -32768, 0)));
    rows.push_back(row_frame(mk(7, -7, 100, -100, -32768, 32767, 0)));
    rows.push_back(row_frame(mk(0, 1, -1, 2, -2, 3, 1)));

    for (k = 0; k < rows.size(); k++) begin
      r = rows[k];
      if (r.is_cfg) begin
        if (!cfg_open) wait_drained(SETTLE);
        write_reg(r.idx, r.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_we <= 1'b0;
          cfg_open = 1'b0;
        end
        offer_frame(r.frame, pick_gap(), r.typed, r.want);
      end
    end

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          cc_d = 2;
          wr_d = 1;
          fs_d = 44739;
        end
        1: begin
          cc_d = 6;
          wr_d = 24;
          fs_d = 89477;
        end
        3: begin
          cc_d = 6;
          wr_d = 3;
          fs_d = 0;
        end
        4: begin
          cc_d = CFG_DATA_W'($urandom_range(0, 131071));
          wr_d = 2;
          fs_d = 1;
        end
        default: begin
          cc_d = CFG_DATA_W'($urandom_range(0, 131071));
          wr_d = CFG_DATA_W'($urandom_range(0, 131071));
          fs_d = CFG_DATA_W'($urandom_range(0, 131071));
        end
      endcase
      wait_drained(SETTLE);
      write_reg(REG_CHAN_COUNT, cc_d);
      write_reg(REG_WHOLE_REPEATS, wr_d);
      write_reg(REG_FRAC_STEP, fs_d);
      cfg_we <= 1'b0;
      no_idle = (p == 3);
      for (i = 0; i < PHASE_FRAMES; i++) begin
        if (p == 1 && i == 3) sink_long_hold = 1'b1;
        if (p == 4 && i == 12) wait_drained(0);
        k = $urandom_range(0, 9);
        for (c = 0; c < MAX_CHAN; c++) begin
          if (k < 6) begin
            f.ch[c] = sample_t'($urandom);
          end else if (k < 9) begin
            f.ch[c] = last_sent.ch[c] + sample_t'(int'($urandom_range(0, 64)) - 32);
          end else begin
            case ($urandom_range(0, 3))
              0: f.ch[c] = 16'sh7FFF;
              1: f.ch[c] = 16'sh8000;
              2: f.ch[c] = 16'sh0000;
              default: f.ch[c] = 16'shFFFF;
            endcase
          end
        end
        f.flag = ($urandom_range(0, 7) == 0);
        offer_frame(f, no_idle ? 0 : pick_gap(), 1'b0, '0);
        last_sent = f;
      end
    end

    wait_drained(SETTLE);
    $display("Run covered %0d input frames, %0d output beats checked, %0d register writes.",
             frame_count, beat_count, cfg_count);
    $display("Settings spanned saturating, zero-repeat and fractional counts; %0d mismatches.",
             err_count);
    if (err_count == 0) begin
      $display("pcm_linear_upsampler_unit regression: pass");
    end else begin
      $display("pcm_linear_upsampler_unit regression: fail");
    end
    $finish;
  end

endmodule
